// ----- rtl/core/assert_macros.svh -----
// shared assertion macros for the receiver core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside of reset
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside of reset
`define SFR_NEVER(lbl, clk, rst_n, cond, msg) \
	`SFR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/core/sfr_pkg.sv -----
package sfr_pkg;

	// crc16 ccitt-false constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// register reset values
	localparam logic [7:0] SYNC_FIRST_RST = 8'd170;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd85;
	localparam logic [7:0] MAX_LEN_RST = 8'd35;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SYNC_FIRST = 2'd0,
		REG_SYNC_SECOND = 2'd1,
		REG_MAX_LEN = 2'd2,
		REG_UNUSED = 2'd3
	} reg_idx_t;

	// receive phase of the frame parser
	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_LENGTH,
		PH_TYPE,
		PH_PAYLOAD,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	// work handed from the front to the back
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TYPE,
		OP_PAYLOAD,
		OP_CRC_LO,
		OP_CRC_HI
	} op_t;

	// event codes on the result stream
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_DATA = 2'd1,
		EV_GOOD = 2'd2,
		EV_BAD = 2'd3
	} event_t;

	// one queue entry
	typedef struct packed {
		op_t op;
		logic [7:0] data;
		logic [7:0] idx;
		logic [7:0] kind;
		logic [7:0] plen;
	} q_entry_t;

	// one result beat
	typedef struct packed {
		event_t ev;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_kind;
		logic [7:0] payload_length;
		logic [15:0] bad_total;
	} result_t;

	// byte-wise crc update, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/sfr_front.sv -----
`include "assert_macros.svh"

module sfr_front (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	// incoming bytes
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	// queue write side
	output logic              push,
	output sfr_pkg::q_entry_t push_entry,
	input  logic              q_ready
);
	import sfr_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] max_len_q;
	phase_t     phase_q;
	phase_t     phase_nxt;
	logic [7:0] length_q;
	logic [7:0] kind_q;
	logic [7:0] count_q;
	logic       accept;
	logic [7:0] len_m1;
	logic [7:0] byte_len_m1;
	logic [7:0] count_inc;

	assign cfg_ready = 1'b1;
	assign in_ready = q_ready;
	assign accept = in_valid & q_ready;
	assign len_m1 = length_q - 8'd1;
	assign byte_len_m1 = in_byte - 8'd1;
	assign count_inc = count_q + 8'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SYNC_FIRST: sync_first_q <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				REG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_SYNC1: if (in_byte == sync_first_q) phase_nxt = PH_SYNC2;
			PH_SYNC2: begin
				if (in_byte == sync_second_q)
					phase_nxt = PH_LENGTH;
				else if (in_byte != sync_first_q)
					phase_nxt = PH_SYNC1;
			end
			PH_LENGTH: begin
				if (in_byte == 8'd0 || byte_len_m1 > max_len_q)
					phase_nxt = PH_SYNC1;
				else
					phase_nxt = PH_TYPE;
			end
			PH_TYPE: phase_nxt = (length_q > 8'd1) ? PH_PAYLOAD : PH_CRC_LO;
			PH_PAYLOAD: if (count_inc >= len_m1) phase_nxt = PH_CRC_LO;
			PH_CRC_LO: phase_nxt = PH_CRC_HI;
			PH_CRC_HI: phase_nxt = PH_SYNC1;
			default: phase_nxt = PH_SYNC1;
		endcase
	end

	// classify the byte into a queue entry
	always_comb begin
		push = accept;
		push_entry.op = OP_NONE;
		push_entry.data = in_byte;
		push_entry.idx = count_q;
		push_entry.kind = kind_q;
		push_entry.plen = len_m1;
		case (phase_q)
			PH_TYPE: push_entry.op = OP_TYPE;
			PH_PAYLOAD: push_entry.op = OP_PAYLOAD;
			PH_CRC_LO: push_entry.op = OP_CRC_LO;
			PH_CRC_HI: push_entry.op = OP_CRC_HI;
			default: push_entry.op = OP_NONE;
		endcase
	end

	// phase and frame header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			length_q <= 8'd0;
			kind_q <= 8'd0;
			count_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if (phase_q == PH_LENGTH)
				length_q <= in_byte;
			if (phase_q == PH_TYPE) begin
				kind_q <= in_byte;
				count_q <= 8'd0;
			end
			if (phase_q == PH_PAYLOAD)
				count_q <= count_inc;
		end
	end

	`SFR_ASSERT(a_count_in_frame, clk, arst_n, (phase_q == PH_PAYLOAD) |-> ({1'b0, count_q} + 9'd1 < {1'b0, length_q}), "payload index beyond frame length")
	`SFR_NEVER(a_push_unready, clk, arst_n, push && !q_ready, "byte pushed while queue full")

endmodule

// ----- rtl/core/sfr_queue.sv -----
`include "assert_macros.svh"

module sfr_queue #(
	parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfr_pkg::q_entry_t push_entry,
	output logic              ready,
	output logic              valid,
	output sfr_pkg::q_entry_t head,
	input  logic              pop
);
	import sfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready = (count_q != CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push & ready;
	assign do_pop = pop & valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`SFR_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue fill count beyond depth")

endmodule

// ----- rtl/core/sfr_back.sv -----
`include "assert_macros.svh"

module sfr_back (
	input  logic              clk,
	input  logic              arst_n,
	// queue read side
	input  logic              q_valid,
	input  sfr_pkg::q_entry_t q_head,
	output logic              q_pop,
	// result beat
	output logic              out_valid,
	input  logic              out_ready,
	output sfr_pkg::result_t  out_res
);
	import sfr_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  crc_low_q;
	logic [15:0] bad_q;
	logic        valid_q;
	result_t     res_q;
	logic [15:0] crc_nxt;
	logic        crc_match;
	logic [15:0] bad_nxt;
	result_t     res_nxt;

	assign q_pop = q_valid & (~valid_q | out_ready);
	assign out_valid = valid_q;
	assign out_res = res_q;
	assign crc_nxt = crc16_byte((q_head.op == OP_TYPE) ? CRC_INIT : crc_q, q_head.data);
	assign crc_match = ({q_head.data, crc_low_q} == crc_q);
	assign bad_nxt = (q_head.op == OP_CRC_HI && !crc_match) ? bad_q + 16'd1 : bad_q;

	// result fields for the head entry
	always_comb begin
		res_nxt.ev = EV_NONE;
		res_nxt.data_byte = 8'd0;
		res_nxt.byte_index = 8'd0;
		res_nxt.frame_kind = 8'd0;
		res_nxt.payload_length = 8'd0;
		res_nxt.bad_total = bad_nxt;
		case (q_head.op)
			OP_PAYLOAD: begin
				res_nxt.ev = EV_DATA;
				res_nxt.data_byte = q_head.data;
				res_nxt.byte_index = q_head.idx;
				res_nxt.frame_kind = q_head.kind;
				res_nxt.payload_length = q_head.plen;
			end
			OP_CRC_HI: begin
				res_nxt.ev = crc_match ? EV_GOOD : EV_BAD;
				res_nxt.frame_kind = q_head.kind;
				res_nxt.payload_length = q_head.plen;
			end
			default: res_nxt.ev = EV_NONE;
		endcase
	end

	// crc, bad frame count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			crc_low_q <= 8'd0;
			bad_q <= 16'd0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				bad_q <= bad_nxt;
				if (q_head.op == OP_TYPE || q_head.op == OP_PAYLOAD)
					crc_q <= crc_nxt;
				if (q_head.op == OP_CRC_LO)
					crc_low_q <= q_head.data;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= res_nxt;
	end

	`SFR_ASSERT(a_bad_only_on_crc, clk, arst_n, (bad_q != $past(bad_q)) |-> $past(q_pop && q_head.op == OP_CRC_HI), "bad count moved without a frame end")
	`SFR_ASSERT(a_bad_matches_beat, clk, arst_n, ($past(q_pop) && $past(q_head.op) == OP_CRC_HI) |-> (res_q.bad_total == bad_q), "reported bad count differs from counter")

endmodule

// ----- rtl/core/sync_frame_receiver_crc16_top.sv -----
// sync/length frame receiver with crc16 ccitt-false check
// s_axis: one received byte per beat in tdata[7:0]
// m_axis: one result beat per received byte, in order; tuser gives the event
//   (0 nothing, 1 payload byte, 2 frame good, 3 crc mismatch)
// cfg: index 0 first sync byte, 1 second sync byte, 2 payload length limit;
//   cfg_ready is always high, writes are meant for an idle block
// path: a taken byte is written into the queue, then popped into the output beat register
// throughput: one byte per cycle; the frame parser classifies each byte in the
//   cycle it is taken, the crc byte update runs one byte per cycle in the back end
// a stalled m_axis fills the queue (QUEUE_DEPTH entries) and then drops
//   s_axis_tready; nothing is lost or repeated
// reset: parser hunts for the first sync byte, crc back to 0xffff, bad-frame
//   count to zero, registers to 170, 85 and 35
module sync_frame_receiver_crc16_top #(
	parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] data_byte, [15:8] byte_index, [23:16] frame_kind,
	// [31:24] payload_length, [47:32] bad_frame_total
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser    // [1:0] event_res
);
	import sfr_pkg::*;

	logic     push;
	q_entry_t push_entry;
	logic     q_ready;
	logic     q_valid;
	q_entry_t q_head;
	logic     q_pop;
	result_t  res;

	// byte classification and frame parsing
	sfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	// decoupling queue
	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.ready      (q_ready),
		.valid      (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	// crc check and result beat
	sfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// pack the result beat
	assign m_axis_tuser = res.ev;
	assign m_axis_tdata = {res.bad_total, res.payload_length, res.frame_kind,
		res.byte_index, res.data_byte};

endmodule
